### sv/sawc_pkg.sv
// shared types, constants and address helpers of the set-associative write-back cache
// no dependencies
package sawc_pkg;

  localparam int WAY_COUNT  = 4;
  localparam int SET_COUNT  = 64;
  localparam int LINE_BYTES = 32;
  localparam int NUM_LINES  = WAY_COUNT * SET_COUNT;
  localparam int DATA_BYTES = NUM_LINES * LINE_BYTES;

  localparam int OFF_W  = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1;
  localparam int SET_SH = $clog2(SET_COUNT);
  localparam int SET_W  = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;
  localparam int WAY_W  = (WAY_COUNT > 1) ? $clog2(WAY_COUNT) : 1;
  localparam int LINE_W = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
  localparam int BYTE_W = $clog2(DATA_BYTES);
  localparam int TOFF_W = OFF_W + 1;

  localparam logic [31:0] POISON    = 32'hBAAAAAAD;
  localparam logic [31:0] LINE_MASK = ~(32'(LINE_BYTES) - 32'd1);

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;

  localparam logic [1:0] CMD_NONE  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;

  typedef logic [OFF_W-1:0]  off_t;
  typedef logic [SET_W-1:0]  set_t;
  typedef logic [WAY_W-1:0]  way_t;
  typedef logic [LINE_W-1:0] line_t;
  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [TOFF_W-1:0] toff_t;

  typedef struct packed {
    logic [31:0] line_addr;
    set_t        lset;
    way_t        way;
    logic        is_write;
  } line_op_t;

  typedef struct packed {
    logic valid;
    logic dirty;
  } line_meta_t;

  typedef enum logic [4:0] {
    DP_NOP,
    DP_LATCH,
    DP_LOOK_RD,
    DP_WAY_NEXT,
    DP_BYTE_RD,
    DP_BYTE_ACC,
    DP_BYTE_WR,
    DP_HIT_DONE,
    DP_MISS_RD,
    DP_MISS,
    DP_MISS_WB,
    DP_RUN_XFER,
    DP_FILL_LO,
    DP_FILL_HI,
    DP_CHK_POP,
    DP_ISSUE_RD,
    DP_WB_LO,
    DP_WB_HI,
    DP_WB_SET
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic clearing;
    logic active;
    logic pend_zero;
    logic mem_busy;
    logic awaiting;
    logic head_write;
    logic hit;
    logic last_way;
    logic req_write;
    logic bytes_left;
    logic victim_dirty;
    logic line_end;
  } dp_stat_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DECIDE,
    S_LOOK_RD,
    S_LOOK_CMP,
    S_HIT_RD,
    S_HIT_RDQ,
    S_HIT_WR,
    S_MISS,
    S_MISS_WB,
    S_RUN,
    S_FILL_LO,
    S_FILL_HI,
    S_CHK,
    S_WB_HI,
    S_WB_SET,
    S_OUT
  } ctrl_state_t;

  function automatic set_t set_of(logic [31:0] a);
    return SET_W'((a >> OFF_W) % SET_COUNT);
  endfunction

  function automatic logic [31:0] tag_of(logic [31:0] a);
    return a >> (OFF_W + SET_SH);
  endfunction

  function automatic line_t line_idx(way_t w, set_t s);
    return LINE_W'(int'(w) * SET_COUNT + int'(s));
  endfunction

  function automatic byte_t byte_idx(line_t l, off_t o);
    return BYTE_W'(int'(l) * LINE_BYTES + int'(o));
  endfunction

endpackage

### sv/sawc_req_if.sv
// request channel: valid/ready handshake carrying one cycle of processor and memory input
// depends on nothing
interface sawc_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [31:0] addr;
  logic [31:0] wdata;
  logic [2:0]  size;
  logic        mem_busy;
  logic [15:0] mem_rdata;

  modport source (output valid, op, addr, wdata, size, mem_busy, mem_rdata, input ready);
  modport sink (input valid, op, addr, wdata, size, mem_busy, mem_rdata, output ready);
endinterface

### sv/sawc_rsp_if.sv
// result channel: valid/ready handshake carrying completion, read data and memory command
// depends on nothing
interface sawc_rsp_if;
  logic        valid;
  logic        ready;
  logic        done_res;
  logic [31:0] rdata;
  logic [1:0]  mem_cmd;
  logic [31:0] mem_addr;
  logic [15:0] mem_wdata;

  modport source (output valid, done_res, rdata, mem_cmd, mem_addr, mem_wdata, input ready);
  modport sink (input valid, done_res, rdata, mem_cmd, mem_addr, mem_wdata, output ready);
endinterface

### sv/sawc_dp.sv
// cache datapath: request registers, tag, data, line state and victim pointer memories
// depends on sawc_pkg
module sawc_dp (
  input  logic               clk,
  input  logic               rst,
  input  sawc_pkg::dp_cmd_t  cmd,
  output sawc_pkg::dp_stat_t stat,
  input  logic [1:0]         op,
  input  logic [31:0]        addr,
  input  logic [31:0]        wdata,
  input  logic [2:0]         size,
  input  logic               mem_busy,
  input  logic [15:0]        mem_rdata,
  output logic               done_res,
  output logic [31:0]        rdata,
  output logic [1:0]         mem_cmd,
  output logic [31:0]        mem_addr,
  output logic [15:0]        mem_wdata
);

  logic                       busy_q;
  logic [15:0]                mrd_q;
  logic                       req_write;
  logic [31:0]                req_addr;
  logic [31:0]                req_data;
  logic [2:0]                 req_size;
  logic                       req_done;
  sawc_pkg::line_op_t         q [2];
  logic [1:0]                 pcount;
  sawc_pkg::toff_t            toff;
  logic                       awaiting;
  sawc_pkg::way_t             wcnt;
  logic [2:0]                 bcnt;
  logic [31:0]                acc;
  sawc_pkg::way_t             vway;
  logic [1:0]                 cmd_kind;
  logic [31:0]                cmd_addr;
  logic [15:0]                cmd_wdata;
  logic                       clearing;
  sawc_pkg::line_t            clr_idx;

  logic [7:0]                 dmem [sawc_pkg::DATA_BYTES];
  logic [7:0]                 dmem_q;
  logic [31:0]                amem [sawc_pkg::NUM_LINES];
  logic [31:0]                amem_q;
  sawc_pkg::line_meta_t       meta [sawc_pkg::NUM_LINES];
  sawc_pkg::line_meta_t       meta_q;
  sawc_pkg::way_t             vptr [sawc_pkg::SET_COUNT];
  sawc_pkg::way_t             vptr_q;

  sawc_pkg::set_t             rset;
  sawc_pkg::off_t             roff;
  sawc_pkg::off_t             hoff;
  sawc_pkg::off_t             toff_lo;
  sawc_pkg::off_t             toff_hi;
  sawc_pkg::line_t            li_look;
  sawc_pkg::line_t            li_vic;
  sawc_pkg::line_t            li_head;
  sawc_pkg::way_t             vcur;
  logic                       hi_fits;
  logic                       vic_dirty;

  logic                       d_we;
  logic                       d_re;
  sawc_pkg::byte_t            d_waddr;
  sawc_pkg::byte_t            d_raddr;
  logic [7:0]                 d_wdat;
  logic                       a_we;
  logic                       a_re;
  sawc_pkg::line_t            a_waddr;
  sawc_pkg::line_t            a_raddr;
  logic                       m_we;
  logic                       m_re;
  sawc_pkg::line_t            m_waddr;
  sawc_pkg::line_t            m_raddr;
  sawc_pkg::line_meta_t       m_wdat;
  logic                       v_we;
  logic                       v_re;
  sawc_pkg::set_t             v_waddr;
  sawc_pkg::way_t             v_wdat;

  assign rset    = sawc_pkg::set_of(req_addr);
  assign roff    = sawc_pkg::off_t'(req_addr);
  assign hoff    = sawc_pkg::off_t'(32'(roff) + 32'(bcnt));
  assign toff_lo = sawc_pkg::off_t'(toff);
  assign toff_hi = sawc_pkg::off_t'(32'(toff) + 32'd1);
  // victim pointer is read with the lookup, victim state right after the last probe
  assign vcur    = vptr_q;
  assign li_look = sawc_pkg::line_idx(wcnt, rset);
  assign li_vic  = sawc_pkg::line_idx(vcur, rset);
  assign li_head = sawc_pkg::line_idx(q[0].way, q[0].lset);
  assign hi_fits = (32'(toff) + 32'd1) < 32'(sawc_pkg::LINE_BYTES);
  assign vic_dirty = meta_q.valid & meta_q.dirty;

  always_comb begin
    stat.clearing     = clearing;
    stat.active       = !req_done;
    stat.pend_zero    = (pcount == 2'd0);
    stat.mem_busy     = busy_q;
    stat.awaiting     = awaiting;
    stat.head_write   = q[0].is_write;
    stat.hit          = meta_q.valid &&
                        (sawc_pkg::tag_of(amem_q) == sawc_pkg::tag_of(req_addr));
    stat.last_way     = (wcnt == sawc_pkg::WAY_W'(sawc_pkg::WAY_COUNT - 1));
    stat.req_write    = req_write;
    stat.bytes_left   = (bcnt < req_size);
    stat.victim_dirty = vic_dirty;
    stat.line_end     = 32'(toff) >= 32'(sawc_pkg::LINE_BYTES);
  end

  // memory port selection
  always_comb begin
    d_we    = 1'b0;
    d_re    = 1'b0;
    d_waddr = sawc_pkg::byte_idx(li_head, toff_lo);
    d_raddr = sawc_pkg::byte_idx(li_head, toff_lo);
    d_wdat  = mrd_q[7:0];
    a_we    = 1'b0;
    a_re    = 1'b0;
    a_waddr = li_head;
    a_raddr = li_look;
    m_we    = 1'b0;
    m_re    = 1'b0;
    m_waddr = li_head;
    m_raddr = li_look;
    m_wdat  = '0;
    v_we    = 1'b0;
    v_re    = 1'b0;
    v_waddr = rset;
    v_wdat  = (vcur == sawc_pkg::WAY_W'(sawc_pkg::WAY_COUNT - 1)) ?
              '0 : vcur + sawc_pkg::WAY_W'(1);
    case (cmd.op)
      sawc_pkg::DP_BYTE_RD: begin
        d_re    = 1'b1;
        d_raddr = sawc_pkg::byte_idx(li_look, hoff);
      end
      sawc_pkg::DP_BYTE_WR: begin
        d_we    = 1'b1;
        d_waddr = sawc_pkg::byte_idx(li_look, hoff);
        d_wdat  = req_data[{bcnt[1:0], 3'b000} +: 8];
      end
      sawc_pkg::DP_FILL_LO: begin
        d_we = 1'b1;
      end
      sawc_pkg::DP_FILL_HI: begin
        d_we    = hi_fits;
        d_waddr = sawc_pkg::byte_idx(li_head, toff_hi);
        d_wdat  = mrd_q[15:8];
      end
      sawc_pkg::DP_WB_LO: begin
        d_re = 1'b1;
      end
      sawc_pkg::DP_WB_HI: begin
        d_re    = hi_fits;
        d_raddr = sawc_pkg::byte_idx(li_head, toff_hi);
      end
      sawc_pkg::DP_LOOK_RD: begin
        a_re = 1'b1;
        m_re = 1'b1;
        v_re = 1'b1;
      end
      sawc_pkg::DP_MISS_RD: begin
        a_re    = 1'b1;
        a_raddr = li_vic;
        m_re    = 1'b1;
        m_raddr = li_vic;
      end
      sawc_pkg::DP_MISS: begin
        v_we = 1'b1;
      end
      sawc_pkg::DP_HIT_DONE: begin
        m_we    = req_write;
        m_waddr = li_look;
        m_wdat  = '{valid: 1'b1, dirty: 1'b1};
      end
      sawc_pkg::DP_CHK_POP: begin
        a_we   = !q[0].is_write;
        m_we   = 1'b1;
        m_wdat = '{valid: 1'b1, dirty: 1'b0};
      end
      default: begin
      end
    endcase
    // clearing pass after reset: one line and one set pointer per cycle
    if (clearing) begin
      m_we    = 1'b1;
      m_waddr = clr_idx;
      m_wdat  = '0;
      v_we    = 1'b1;
      v_waddr = sawc_pkg::set_t'(clr_idx);
      v_wdat  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (d_we) begin
      dmem[d_waddr] <= d_wdat;
    end
    if (d_re) begin
      dmem_q <= dmem[d_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (a_we) begin
      amem[a_waddr] <= q[0].line_addr;
    end
    if (a_re) begin
      amem_q <= amem[a_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (m_we) begin
      meta[m_waddr] <= m_wdat;
    end
    if (m_re) begin
      meta_q <= meta[m_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (v_we) begin
      vptr[v_waddr] <= v_wdat;
    end
    if (v_re) begin
      vptr_q <= vptr[rset];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      req_done  <= 1'b1;
      req_data  <= '0;
      req_write <= 1'b0;
      req_addr  <= '0;
      req_size  <= '0;
      pcount    <= '0;
      toff      <= '0;
      awaiting  <= 1'b0;
      cmd_kind  <= sawc_pkg::CMD_NONE;
      cmd_addr  <= '0;
      cmd_wdata <= '0;
      clearing  <= 1'b1;
      clr_idx   <= '0;
    end else begin
      if (clearing) begin
        clr_idx <= clr_idx + sawc_pkg::LINE_W'(1);
        if (clr_idx == sawc_pkg::LINE_W'(sawc_pkg::NUM_LINES - 1)) begin
          clearing <= 1'b0;
        end
      end
      case (cmd.op)
        sawc_pkg::DP_LATCH: begin
          busy_q    <= mem_busy;
          mrd_q     <= mem_rdata;
          cmd_kind  <= sawc_pkg::CMD_NONE;
          cmd_addr  <= '0;
          cmd_wdata <= '0;
          wcnt      <= '0;
          bcnt      <= '0;
          acc       <= '0;
          if (op == sawc_pkg::OP_READ || op == sawc_pkg::OP_WRITE) begin
            req_write <= (op == sawc_pkg::OP_WRITE);
            req_addr  <= addr;
            req_size  <= (size > 3'd4) ? 3'd4 : size;
            req_data  <= (op == sawc_pkg::OP_WRITE) ? wdata : sawc_pkg::POISON;
            req_done  <= 1'b0;
          end
        end
        sawc_pkg::DP_WAY_NEXT: begin
          wcnt <= wcnt + sawc_pkg::WAY_W'(1);
        end
        sawc_pkg::DP_BYTE_ACC: begin
          acc  <= acc | (32'(dmem_q) << {bcnt[1:0], 3'b000});
          bcnt <= bcnt + 3'd1;
        end
        sawc_pkg::DP_BYTE_WR: begin
          bcnt <= bcnt + 3'd1;
        end
        sawc_pkg::DP_HIT_DONE: begin
          req_done <= 1'b1;
          if (!req_write) begin
            req_data <= acc;
          end
        end
        sawc_pkg::DP_MISS: begin
          toff     <= '0;
          awaiting <= 1'b0;
          vway     <= vcur;
          if (!vic_dirty) begin
            q[0]   <= '{line_addr: req_addr & sawc_pkg::LINE_MASK, lset: rset,
                        way: vcur, is_write: 1'b0};
            pcount <= 2'd1;
          end
        end
        sawc_pkg::DP_MISS_WB: begin
          q[0]   <= '{line_addr: amem_q & sawc_pkg::LINE_MASK, lset: rset,
                      way: vway, is_write: 1'b1};
          q[1]   <= '{line_addr: req_addr & sawc_pkg::LINE_MASK, lset: rset,
                      way: vway, is_write: 1'b0};
          pcount <= 2'd2;
        end
        sawc_pkg::DP_RUN_XFER, sawc_pkg::DP_FILL_HI: begin
          awaiting <= 1'b0;
          toff     <= toff + sawc_pkg::TOFF_W'(2);
        end
        sawc_pkg::DP_CHK_POP: begin
          if (pcount > 2'd1) begin
            q[0] <= q[1];
          end
          pcount   <= pcount - 2'd1;
          toff     <= '0;
          awaiting <= 1'b0;
        end
        sawc_pkg::DP_ISSUE_RD: begin
          cmd_kind <= sawc_pkg::CMD_READ;
          cmd_addr <= q[0].line_addr + 32'(toff);
          awaiting <= 1'b1;
        end
        sawc_pkg::DP_WB_HI: begin
          cmd_wdata[7:0] <= dmem_q;
        end
        sawc_pkg::DP_WB_SET: begin
          cmd_wdata[15:8] <= hi_fits ? dmem_q : 8'd0;
          cmd_kind        <= sawc_pkg::CMD_WRITE;
          cmd_addr        <= q[0].line_addr + 32'(toff);
          awaiting        <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  assign done_res  = req_done;
  assign rdata     = req_done ? req_data : sawc_pkg::POISON;
  assign mem_cmd   = cmd_kind;
  assign mem_addr  = cmd_addr;
  assign mem_wdata = cmd_wdata;

endmodule

### sv/sawc_ctrl.sv
// cache sequencer: walks lookup, hit access, miss setup and line transfer steps per beat
// depends on sawc_pkg
module sawc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  sawc_pkg::dp_stat_t stat,
  output sawc_pkg::dp_cmd_t  cmd
);

  sawc_pkg::ctrl_state_t state;
  sawc_pkg::ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sawc_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.op     = sawc_pkg::DP_NOP;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    case (state)
      sawc_pkg::S_IDLE: begin
        in_ready = !stat.clearing;
        if (in_valid && !stat.clearing) begin
          cmd.op     = sawc_pkg::DP_LATCH;
          state_next = sawc_pkg::S_DECIDE;
        end
      end
      sawc_pkg::S_DECIDE: begin
        if (stat.active && stat.pend_zero) begin
          state_next = sawc_pkg::S_LOOK_RD;
        end else if (stat.active) begin
          state_next = sawc_pkg::S_RUN;
        end else begin
          state_next = sawc_pkg::S_OUT;
        end
      end
      sawc_pkg::S_LOOK_RD: begin
        cmd.op     = sawc_pkg::DP_LOOK_RD;
        state_next = sawc_pkg::S_LOOK_CMP;
      end
      sawc_pkg::S_LOOK_CMP: begin
        if (stat.hit) begin
          state_next = stat.req_write ? sawc_pkg::S_HIT_WR : sawc_pkg::S_HIT_RD;
        end else if (stat.last_way) begin
          cmd.op     = sawc_pkg::DP_MISS_RD;
          state_next = sawc_pkg::S_MISS;
        end else begin
          cmd.op     = sawc_pkg::DP_WAY_NEXT;
          state_next = sawc_pkg::S_LOOK_RD;
        end
      end
      sawc_pkg::S_HIT_RD: begin
        if (stat.bytes_left) begin
          cmd.op     = sawc_pkg::DP_BYTE_RD;
          state_next = sawc_pkg::S_HIT_RDQ;
        end else begin
          cmd.op     = sawc_pkg::DP_HIT_DONE;
          state_next = sawc_pkg::S_RUN;
        end
      end
      sawc_pkg::S_HIT_RDQ: begin
        cmd.op     = sawc_pkg::DP_BYTE_ACC;
        state_next = sawc_pkg::S_HIT_RD;
      end
      sawc_pkg::S_HIT_WR: begin
        if (stat.bytes_left) begin
          cmd.op = sawc_pkg::DP_BYTE_WR;
        end else begin
          cmd.op     = sawc_pkg::DP_HIT_DONE;
          state_next = sawc_pkg::S_RUN;
        end
      end
      sawc_pkg::S_MISS: begin
        cmd.op     = sawc_pkg::DP_MISS;
        state_next = stat.victim_dirty ? sawc_pkg::S_MISS_WB : sawc_pkg::S_RUN;
      end
      sawc_pkg::S_MISS_WB: begin
        cmd.op     = sawc_pkg::DP_MISS_WB;
        state_next = sawc_pkg::S_RUN;
      end
      sawc_pkg::S_RUN: begin
        if (stat.pend_zero || stat.mem_busy) begin
          state_next = sawc_pkg::S_OUT;
        end else if (stat.awaiting && !stat.head_write) begin
          state_next = sawc_pkg::S_FILL_LO;
        end else if (stat.awaiting) begin
          cmd.op     = sawc_pkg::DP_RUN_XFER;
          state_next = sawc_pkg::S_CHK;
        end else begin
          state_next = sawc_pkg::S_CHK;
        end
      end
      sawc_pkg::S_FILL_LO: begin
        cmd.op     = sawc_pkg::DP_FILL_LO;
        state_next = sawc_pkg::S_FILL_HI;
      end
      sawc_pkg::S_FILL_HI: begin
        cmd.op     = sawc_pkg::DP_FILL_HI;
        state_next = sawc_pkg::S_CHK;
      end
      sawc_pkg::S_CHK: begin
        if (stat.line_end) begin
          cmd.op     = sawc_pkg::DP_CHK_POP;
          state_next = sawc_pkg::S_RUN;
        end else if (!stat.awaiting && stat.head_write) begin
          cmd.op     = sawc_pkg::DP_WB_LO;
          state_next = sawc_pkg::S_WB_HI;
        end else if (!stat.awaiting) begin
          cmd.op     = sawc_pkg::DP_ISSUE_RD;
          state_next = sawc_pkg::S_OUT;
        end else begin
          state_next = sawc_pkg::S_OUT;
        end
      end
      sawc_pkg::S_WB_HI: begin
        cmd.op     = sawc_pkg::DP_WB_HI;
        state_next = sawc_pkg::S_WB_SET;
      end
      sawc_pkg::S_WB_SET: begin
        cmd.op     = sawc_pkg::DP_WB_SET;
        state_next = sawc_pkg::S_OUT;
      end
      sawc_pkg::S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = sawc_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = sawc_pkg::S_IDLE;
      end
    endcase
  end

endmodule

### sv/set_assoc_writeback_cache_fifo.sv
// top level of the set-associative write-back cache with round-robin victim choice
// depends on sawc_pkg, sawc_req_if, sawc_rsp_if, sawc_ctrl, sawc_dp
//
// usage:
//   req carries one simulated cycle of the cache per beat: a processor op (tick, new read,
//   new write), its address, write data and size, plus the memory's busy flag and the
//   16-bit data of the last completed memory read.
//   rsp returns exactly one beat per req beat: completion, read data (0xBAAAAAAD while
//   not done) and at most one 2-byte memory command with address and write data.
// throughput:
//   one req beat at a time. an idle tick goes from the decision straight to rsp valid; a
//   lookup probes one way at a time, a hit reads or writes one byte at a time and then
//   finishes, a miss adds a setup step and one more with a dirty victim, and each line
//   transfer step walks its own states. the pace comes from the tag, line state and data
//   memories with one read and one write port each and from the byte-wide data array.
// reset (rst, synchronous): transfer queue empty, request idle and done with read data
//   zero, then a clearing pass, one line per cycle, marks all lines invalid and
//   clean and zeroes the victim pointers; req.ready stays low until it ends. tag and data
//   memories are not cleared; their contents are only used once a line has been filled.
// stalls: while rsp.ready is low the result is held and req.ready stays low
module set_assoc_writeback_cache_fifo (
  input logic       clk,
  input logic       rst,
  sawc_req_if.sink  req,
  sawc_rsp_if.source rsp
);

  sawc_pkg::dp_cmd_t  cmd;
  sawc_pkg::dp_stat_t stat;

  // sequencer: owns both handshakes and steps the datapath
  sawc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // datapath: payload is latched on the accepted beat, result held until taken
  sawc_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .op        (req.op),
    .addr      (req.addr),
    .wdata     (req.wdata),
    .size      (req.size),
    .mem_busy  (req.mem_busy),
    .mem_rdata (req.mem_rdata),
    .done_res  (rsp.done_res),
    .rdata     (rsp.rdata),
    .mem_cmd   (rsp.mem_cmd),
    .mem_addr  (rsp.mem_addr),
    .mem_wdata (rsp.mem_wdata)
  );

endmodule
